FILE: design/bjdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjdr_pkg: shared types and constants for the joystick/button debouncer
// Key codes, phase encoding and the per-tick state and result records.
// ----------------------------------------------------------------------------
package bjdr_pkg;

	localparam int JOY_LINES   = 5;
	localparam int NUM_BUTTONS = 3;
	localparam int CNT_W       = 8;
	localparam int KEY_W       = 4;

	localparam logic [CNT_W-1:0] REARM_RESET = 8'd10;

	localparam logic [KEY_W-1:0] KEY_NONE     = 4'd0;
	localparam logic [KEY_W-1:0] KEY_JOY_BASE = 4'd1;
	localparam logic [KEY_W-1:0] KEY_BTN_BASE = 4'd6;

	localparam logic ACT_PRESSED  = 1'b0;
	localparam logic ACT_RELEASED = 1'b1;

	// Button debounce phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ARMED = 2'd1,
		PH_DOWN  = 2'd2
	} phase_t;

	typedef logic [CNT_W-1:0] cnt_t;

	// Debouncer state
	typedef struct packed {
		cnt_t   [JOY_LINES-1:0]   hold_cnt;
		phase_t [NUM_BUTTONS-1:0] phase;
	} dbc_state_t;

	// One event record per tick
	typedef struct packed {
		logic [NUM_BUTTONS-1:0] irq_reenable;
		logic                   event_action;
		logic [KEY_W-1:0]       event_key;
	} dbc_result_t;

endpackage

FILE: design/button_joystick_debounce_rearm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_joystick_debounce_rearm: joystick and button debouncer with rearm
// Pipeline: input register, then scan logic into the result register. Throughput:
// one tick per cycle while m_axis_tready does not stall the result register; the
// scan updates the hold counts and phases combinationally.
// Reset: hold counts cleared, buttons idle, rearm_count = 10, both stages empty.
// ----------------------------------------------------------------------------
module button_joystick_debounce_rearm
	import bjdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write: rearm_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// input ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [4:0] joystick_levels, [7:5] button_levels, [10:8] button_irq_flags, rest 0
	input  logic [15:0] s_axis_tdata,
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] event_key, [4] event_action, [7:5] irq_reenable
	output logic [7:0]  m_axis_tdata
);

	logic                   valid_s1;
	logic [JOY_LINES-1:0]   joy_s1;
	logic [NUM_BUTTONS-1:0] lev_s1;
	logic [NUM_BUTTONS-1:0] flg_s1;
	cnt_t                   rearm_q;
	dbc_state_t             state_q;
	dbc_state_t             state_nxt;
	dbc_result_t            res_nxt;
	dbc_result_t            res_q;
	logic                   out_valid_q;
	logic                   advance;

	// Stage 1 moves into the result register when that is empty or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm_q <= REARM_RESET;
		end else if (cfg_valid) begin
			rearm_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			joy_s1 <= s_axis_tdata[4:0];
			lev_s1 <= s_axis_tdata[7:5];
			flg_s1 <= s_axis_tdata[10:8];
		end
	end

	// Scan logic
	bjdr_scan u_scan (
		.cur              (state_q),
		.rearm_count      (rearm_q),
		.joystick_levels  (joy_s1),
		.button_levels    (lev_s1),
		.button_irq_flags (flg_s1),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	// Debouncer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOY_LINES; i++)
				state_q.hold_cnt[i] <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++)
				state_q.phase[i] <= PH_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

endmodule

FILE: design/bjdr_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjdr_scan: one-tick scan of joystick lines and push buttons
// Priority scan of the joystick (line 4 first) and the buttons (button 0 first);
// returns the next state and the event for the tick.
// ----------------------------------------------------------------------------
module bjdr_scan
	import bjdr_pkg::*;
(
	input  dbc_state_t             cur,
	input  cnt_t                   rearm_count,
	input  logic [JOY_LINES-1:0]   joystick_levels,
	input  logic [NUM_BUTTONS-1:0] button_levels,
	input  logic [NUM_BUTTONS-1:0] button_irq_flags,
	output dbc_state_t             nxt,
	output dbc_result_t            res
);

	// Joystick: the first held line ends the scan; released lines above it report
	always_comb begin
		logic             done;
		logic [KEY_W-1:0] jkey;
		logic             jact;
		logic [KEY_W-1:0] bkey;
		logic             bact;
		logic             stop;
		cnt_t             c;
		phase_t           ph [NUM_BUTTONS];

		nxt  = cur;
		done = 1'b0;
		jkey = KEY_NONE;
		jact = ACT_PRESSED;
		bkey = KEY_NONE;
		bact = ACT_PRESSED;
		stop = 1'b0;
		c    = '0;
		res.irq_reenable = '0;

		for (int i = JOY_LINES - 1; i >= 0; i--) begin
			if (!done) begin
				if (!joystick_levels[i]) begin
					c = cur.hold_cnt[i] + 8'd1;
					nxt.hold_cnt[i] = c;
					if (c == 8'd1) begin
						jkey = KEY_JOY_BASE + KEY_W'(i);
						jact = ACT_PRESSED;
					end else if (c == rearm_count) begin
						nxt.hold_cnt[i] = '0;
						jkey = KEY_JOY_BASE + KEY_W'(i);
						jact = ACT_RELEASED;
					end
					done = 1'b1;
				end else if (cur.hold_cnt[i] != '0) begin
					nxt.hold_cnt[i] = '0;
					jkey = KEY_JOY_BASE + KEY_W'(i);
					jact = ACT_RELEASED;
				end
			end
		end

		// Arm idle buttons whose interrupt fired
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			ph[i] = cur.phase[i];
			if (cur.phase[i] == PH_IDLE && button_irq_flags[i])
				ph[i] = PH_ARMED;
			nxt.phase[i] = ph[i];
		end

		// Button scan; an armed button reports pressed and stops the scan
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (!stop) begin
				case (ph[i])
					PH_IDLE: begin
					end
					PH_ARMED: begin
						nxt.phase[i] = PH_DOWN;
						bkey = KEY_BTN_BASE + KEY_W'(i);
						bact = ACT_PRESSED;
						stop = 1'b1;
					end
					default: begin
						// down (and the unused code) waits for the line to go high
						if (button_levels[i]) begin
							nxt.phase[i] = PH_IDLE;
							bkey = KEY_BTN_BASE + KEY_W'(i);
							bact = ACT_RELEASED;
							res.irq_reenable[i] = 1'b1;
						end else begin
							nxt.phase[i] = PH_DOWN;
						end
					end
				endcase
			end
		end

		// Joystick event outranks button event
		if (jkey != KEY_NONE) begin
			res.event_key    = jkey;
			res.event_action = jact;
		end else if (bkey != KEY_NONE) begin
			res.event_key    = bkey;
			res.event_action = bact;
		end else begin
			res.event_key    = KEY_NONE;
			res.event_action = ACT_PRESSED;
		end
	end

endmodule
